/* rtl/vsrt_pkg.sv */
// Shared types, constants and the sine table builder for the vertex transform.
// No dependencies; every other file of the block refers to this package by scoped names.
package vsrt_pkg;

	// Default vertex coordinate width, signed Q16.8
	localparam int COORD_WIDTH = 24;

	// Register field widths
	localparam int ANGLE_W    = 16;
	localparam int SCALE_W    = 16;
	localparam int OFFSET_W   = 24;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;

	// Pipeline depth from the accepted word to the output register
	localparam int PIPE_DEPTH = 11;

	// Angle units: 1/128 degree, one full turn and one quadrant
	localparam int ANGLE_FULL    = 46080;
	localparam int ANGLE_QUARTER = 11520;

	// Quarter-wave sine table, Q2.14 magnitudes
	localparam int TRIG_ENTRIES = 1024;
	localparam int TRIG_IDX_W   = $clog2(TRIG_ENTRIES + 1);
	localparam int TRIG_VAL_W   = 15;
	localparam int TRIG_W       = 16;

	// Table index = (r * N + quarter/2) / quarter, with quarter = 2^8 * 45
	localparam int ANGLE_SUB_SH = 8;
	localparam int DIV_RES      = ANGLE_QUARTER >> ANGLE_SUB_SH;
	localparam longint unsigned NUM_MAX =
		longint'(ANGLE_QUARTER - 1) * longint'(TRIG_ENTRIES) + longint'(ANGLE_QUARTER / 2);
	localparam int NUM_W    = $clog2(NUM_MAX + 1);
	localparam int M_W      = NUM_W - ANGLE_SUB_SH;
	localparam int RECIP_SH = M_W + 6;
	localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / DIV_RES;
	localparam int RECIP_W  = $clog2(RECIP + 1);
	localparam int RPROD_W  = M_W + RECIP_W;

	// pi/2 in Q30 for the table series
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [PIPE_DEPTH-1:0] pipe_en_t;

	typedef enum logic [2:0] {
		REG_ANGLE    = 3'd0,
		REG_SCALE_X  = 3'd1,
		REG_SCALE_Y  = 3'd2,
		REG_OFFSET_X = 3'd3,
		REG_OFFSET_Y = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic        [ANGLE_W-1:0]  angle;
		logic signed [SCALE_W-1:0]  scale_x;
		logic signed [SCALE_W-1:0]  scale_y;
		logic signed [OFFSET_W-1:0] offset_x;
		logic signed [OFFSET_W-1:0] offset_y;
	} cfg_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_val;
		logic signed [TRIG_W-1:0] cos_val;
	} trig_pair_t;

	typedef logic [TRIG_VAL_W-1:0] trig_tab_t [TRIG_ENTRIES+1];

	// Build the quarter-wave table: Taylor series in Q30 with truncating steps,
	// rounded to Q14 and limited to 1.0
	function automatic trig_tab_t build_sine_table();
		trig_tab_t              tab;
		longint unsigned        x;
		longint unsigned        x2;
		longint unsigned        term;
		longint unsigned        e;
		longint                 sum;
		for (int k = 0; k <= TRIG_ENTRIES; k++) begin
			x    = (longint'(k) * HALF_PI_Q30) / TRIG_ENTRIES;
			x2   = (x * x) >> 30;
			sum  = longint'(x);
			// Seven terms of alternating sign, term n divided by (2n)(2n+1)
			term = ((x * x2) >> 30) / 64'd6;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd210;
			sum  = sum - longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			e = (longint'(sum) + 64'd32768) >> 16;
			if (e > 64'd16384) begin
				e = 64'd16384;
			end
			tab[k] = TRIG_VAL_W'(e);
		end
		return tab;
	endfunction

endpackage

/* rtl/vsrt_cfg.sv */
// APB-style register file holding angle, per-axis scale and world offset.
// Depends on vsrt_pkg for field widths, register indexes and the cfg_t bundle.
module vsrt_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [vsrt_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [vsrt_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [vsrt_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	output vsrt_pkg::cfg_t                    cfg
);

	vsrt_pkg::cfg_t     cfg_q;
	vsrt_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = vsrt_pkg::reg_idx_t'(paddr[vsrt_pkg::CFG_ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Write the addressed register; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle    <= '0;
			cfg_q.scale_x  <= vsrt_pkg::SCALE_W'(256);
			cfg_q.scale_y  <= vsrt_pkg::SCALE_W'(256);
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				vsrt_pkg::REG_ANGLE:    cfg_q.angle    <= pwdata[vsrt_pkg::ANGLE_W-1:0];
				vsrt_pkg::REG_SCALE_X:  cfg_q.scale_x  <= pwdata[vsrt_pkg::SCALE_W-1:0];
				vsrt_pkg::REG_SCALE_Y:  cfg_q.scale_y  <= pwdata[vsrt_pkg::SCALE_W-1:0];
				vsrt_pkg::REG_OFFSET_X: cfg_q.offset_x <= pwdata[vsrt_pkg::OFFSET_W-1:0];
				vsrt_pkg::REG_OFFSET_Y: cfg_q.offset_y <= pwdata[vsrt_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back, sign-extending the signed fields
	always_comb begin
		case (reg_idx)
			vsrt_pkg::REG_ANGLE:    prdata = vsrt_pkg::CFG_DATA_W'(cfg_q.angle);
			vsrt_pkg::REG_SCALE_X:  prdata = vsrt_pkg::CFG_DATA_W'(cfg_q.scale_x);
			vsrt_pkg::REG_SCALE_Y:  prdata = vsrt_pkg::CFG_DATA_W'(cfg_q.scale_y);
			vsrt_pkg::REG_OFFSET_X: prdata = vsrt_pkg::CFG_DATA_W'(cfg_q.offset_x);
			vsrt_pkg::REG_OFFSET_Y: prdata = vsrt_pkg::CFG_DATA_W'(cfg_q.offset_y);
			default:                prdata = '0;
		endcase
	end

endmodule

/* rtl/vsrt_trig.sv */
// Angle to sine/cosine pipeline: angle reduction, table index, quarter-wave ROM.
// Depends on vsrt_pkg for the table builder, index constants and stage enables.
module vsrt_trig (
	input  logic                          clk,
	input  vsrt_pkg::pipe_en_t            adv,
	input  logic [vsrt_pkg::ANGLE_W-1:0]  angle,
	output vsrt_pkg::trig_pair_t          trig_s6
);

	localparam int IW = vsrt_pkg::TRIG_IDX_W;
	localparam int MW = vsrt_pkg::M_W;
	localparam int HALF_QUARTER = vsrt_pkg::ANGLE_QUARTER / 2;
	localparam vsrt_pkg::trig_tab_t SINE_ROM = vsrt_pkg::build_sine_table();

	logic [vsrt_pkg::ANGLE_W-1:0]     ang_mod;
	logic [vsrt_pkg::ANGLE_W-1:0]     quad_base;
	vsrt_pkg::quad_t                  quad;
	logic [vsrt_pkg::NUM_W-1:0]       num;
	logic [IW-1:0]                    q0;
	logic [MW-1:0]                    rem;
	logic [IW-1:0]                    idx;
	logic [IW-1:0]                    idx_comp;
	logic signed [vsrt_pkg::TRIG_W-1:0] tab_a;
	logic signed [vsrt_pkg::TRIG_W-1:0] tab_b;

	logic [13:0]                      r_s1;
	vsrt_pkg::quad_t                  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5;
	logic [MW-1:0]                    m_s2, m_s3;
	logic [vsrt_pkg::RPROD_W-1:0]     prod_s3;
	logic [IW-1:0]                    idx_s4;
	logic [vsrt_pkg::TRIG_VAL_W-1:0]  tab_a_s5, tab_b_s5;

	// Stage 1: wrap the angle into one turn, split into quadrant and remainder
	always_comb begin
		ang_mod = (angle >= vsrt_pkg::ANGLE_W'(vsrt_pkg::ANGLE_FULL))
			? angle - vsrt_pkg::ANGLE_W'(vsrt_pkg::ANGLE_FULL) : angle;
		if (ang_mod >= vsrt_pkg::ANGLE_W'(3 * vsrt_pkg::ANGLE_QUARTER)) begin
			quad      = vsrt_pkg::QUAD_3;
			quad_base = vsrt_pkg::ANGLE_W'(3 * vsrt_pkg::ANGLE_QUARTER);
		end else if (ang_mod >= vsrt_pkg::ANGLE_W'(2 * vsrt_pkg::ANGLE_QUARTER)) begin
			quad      = vsrt_pkg::QUAD_2;
			quad_base = vsrt_pkg::ANGLE_W'(2 * vsrt_pkg::ANGLE_QUARTER);
		end else if (ang_mod >= vsrt_pkg::ANGLE_W'(vsrt_pkg::ANGLE_QUARTER)) begin
			quad      = vsrt_pkg::QUAD_1;
			quad_base = vsrt_pkg::ANGLE_W'(vsrt_pkg::ANGLE_QUARTER);
		end else begin
			quad      = vsrt_pkg::QUAD_0;
			quad_base = '0;
		end
	end

	// Stage 2: scale the remainder to table steps, pre-divided by 2^8
	assign num = vsrt_pkg::NUM_W'(r_s1) * vsrt_pkg::NUM_W'(vsrt_pkg::TRIG_ENTRIES)
		+ vsrt_pkg::NUM_W'(HALF_QUARTER);

	// Stage 4: reciprocal quotient is low by at most one; fix it up
	assign q0       = IW'(prod_s3 >> vsrt_pkg::RECIP_SH);
	assign rem      = m_s3 - MW'(q0) * MW'(vsrt_pkg::DIV_RES);
	assign idx      = (rem >= MW'(vsrt_pkg::DIV_RES)) ? IW'(q0 + IW'(1)) : q0;
	assign idx_comp = IW'(vsrt_pkg::TRIG_ENTRIES) - idx_s4;

	assign tab_a = vsrt_pkg::TRIG_W'(tab_a_s5);
	assign tab_b = vsrt_pkg::TRIG_W'(tab_b_s5);

	// Advance each stage when the stage ahead can take its word
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			r_s1    <= 14'(ang_mod - quad_base);
			quad_s1 <= quad;
		end
		if (adv[1]) begin
			m_s2    <= num[vsrt_pkg::NUM_W-1:vsrt_pkg::ANGLE_SUB_SH];
			quad_s2 <= quad_s1;
		end
		if (adv[2]) begin
			prod_s3 <= vsrt_pkg::RPROD_W'(m_s2) * vsrt_pkg::RPROD_W'(vsrt_pkg::RECIP);
			m_s3    <= m_s2;
			quad_s3 <= quad_s2;
		end
		if (adv[3]) begin
			idx_s4  <= idx;
			quad_s4 <= quad_s3;
		end
		// Stage 5: two table reads, registered
		if (adv[4]) begin
			tab_a_s5 <= SINE_ROM[idx_s4];
			tab_b_s5 <= SINE_ROM[idx_comp];
			quad_s5  <= quad_s4;
		end
		// Stage 6: place the two entries and their signs by quadrant
		if (adv[5]) begin
			case (quad_s5)
				vsrt_pkg::QUAD_0: begin
					trig_s6.sin_val <= tab_a;
					trig_s6.cos_val <= tab_b;
				end
				vsrt_pkg::QUAD_1: begin
					trig_s6.sin_val <= tab_b;
					trig_s6.cos_val <= -tab_a;
				end
				vsrt_pkg::QUAD_2: begin
					trig_s6.sin_val <= -tab_a;
					trig_s6.cos_val <= -tab_b;
				end
				default: begin
					trig_s6.sin_val <= -tab_b;
					trig_s6.cos_val <= tab_a;
				end
			endcase
		end
	end

endmodule

/* rtl/vsrt_xform.sv */
// Coordinate datapath: per-axis scale, rotation, rounding, offset and saturation.
// Depends on vsrt_pkg for widths and stage enables; takes sine/cosine from vsrt_trig.
module vsrt_xform #(
	parameter int COORD_WIDTH = vsrt_pkg::COORD_WIDTH
) (
	input  logic                                   clk,
	input  vsrt_pkg::pipe_en_t                     adv,
	input  logic signed [COORD_WIDTH-1:0]          local_x,
	input  logic signed [COORD_WIDTH-1:0]          local_y,
	input  vsrt_pkg::cfg_t                         cfg,
	input  vsrt_pkg::trig_pair_t                   trig_s6,
	output logic signed [COORD_WIDTH-1:0]          world_x_s11,
	output logic signed [COORD_WIDTH-1:0]          world_y_s11,
	output logic                                   sat_s11
);

	localparam int PW     = COORD_WIDTH + vsrt_pkg::SCALE_W;
	localparam int PROD_W = PW + vsrt_pkg::TRIG_W;
	localparam int RX_W   = PROD_W + 1;
	localparam int RND_SH = 22;
	localparam int RND_W  = RX_W - RND_SH;
	localparam int SUM_W  = ((RND_W > vsrt_pkg::OFFSET_W) ? RND_W : vsrt_pkg::OFFSET_W) + 1;

	logic signed [RX_W-1:0]        rx_bias;
	logic signed [RX_W-1:0]        ry_bias;
	logic [SUM_W-COORD_WIDTH:0]    top_x;
	logic [SUM_W-COORD_WIDTH:0]    top_y;
	logic                          ovf_x;
	logic                          ovf_y;
	logic signed [COORD_WIDTH-1:0] max_val;
	logic signed [COORD_WIDTH-1:0] min_val;

	logic signed [COORD_WIDTH-1:0] lx_s1, ly_s1;
	logic signed [PW-1:0]          px_s [2:6];
	logic signed [PW-1:0]          py_s [2:6];
	logic signed [PROD_W-1:0]      cx_s7, sx_s7, cy_s7, sy_s7;
	logic signed [RX_W-1:0]        rx_s8, ry_s8;
	logic signed [RND_W-1:0]       rnd_x_s9, rnd_y_s9;
	logic signed [SUM_W-1:0]       sum_x_s10, sum_y_s10;

	// Round Q.30 to Q.8, halves upward
	assign rx_bias = rx_s8 + RX_W'(1 << (RND_SH - 1));
	assign ry_bias = ry_s8 + RX_W'(1 << (RND_SH - 1));

	// Out of range when the coordinate's sign bit and the bits above it disagree
	assign top_x   = sum_x_s10[SUM_W-1:COORD_WIDTH-1];
	assign top_y   = sum_y_s10[SUM_W-1:COORD_WIDTH-1];
	assign ovf_x   = !((&top_x) || !(|top_x));
	assign ovf_y   = !((&top_y) || !(|top_y));
	assign max_val = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	assign min_val = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	always_ff @(posedge clk) begin
		// Capture the accepted word
		if (adv[0]) begin
			lx_s1 <= local_x;
			ly_s1 <= local_y;
		end
		// Scale per axis
		if (adv[1]) begin
			px_s[2] <= PW'(lx_s1) * PW'(cfg.scale_x);
			py_s[2] <= PW'(ly_s1) * PW'(cfg.scale_y);
		end
		// Hold scaled values while the table lookup completes
		for (int k = 3; k <= 6; k++) begin
			if (adv[k-1]) begin
				px_s[k] <= px_s[k-1];
				py_s[k] <= py_s[k-1];
			end
		end
		// Rotation products
		if (adv[6]) begin
			cx_s7 <= PROD_W'(trig_s6.cos_val) * PROD_W'(px_s[6]);
			sx_s7 <= PROD_W'(trig_s6.sin_val) * PROD_W'(px_s[6]);
			cy_s7 <= PROD_W'(trig_s6.cos_val) * PROD_W'(py_s[6]);
			sy_s7 <= PROD_W'(trig_s6.sin_val) * PROD_W'(py_s[6]);
		end
		if (adv[7]) begin
			rx_s8 <= RX_W'(cx_s7) - RX_W'(sy_s7);
			ry_s8 <= RX_W'(sx_s7) + RX_W'(cy_s7);
		end
		if (adv[8]) begin
			rnd_x_s9 <= rx_bias[RX_W-1:RND_SH];
			rnd_y_s9 <= ry_bias[RX_W-1:RND_SH];
		end
		// Add the world offset
		if (adv[9]) begin
			sum_x_s10 <= SUM_W'(rnd_x_s9) + SUM_W'(cfg.offset_x);
			sum_y_s10 <= SUM_W'(rnd_y_s9) + SUM_W'(cfg.offset_y);
		end
		// Clamp into the output register
		if (adv[10]) begin
			world_x_s11 <= ovf_x ? (sum_x_s10[SUM_W-1] ? min_val : max_val)
				: sum_x_s10[COORD_WIDTH-1:0];
			world_y_s11 <= ovf_y ? (sum_y_s10[SUM_W-1] ? min_val : max_val)
				: sum_y_s10[COORD_WIDTH-1:0];
			sat_s11     <= ovf_x | ovf_y;
		end
	end

endmodule

/* rtl/vertex_scale_rotate_translate_top.sv */
// Vertex transform top level: register port, valid/stall control and the two pipelines.
// Depends on vsrt_pkg, vsrt_cfg, vsrt_trig and vsrt_xform.
//
// Transforms vertices from local to world space: scale per axis (Q8.8), rotate by the
// angle register (1/128 degree units, wrapped to one turn) using a 1025-entry
// quarter-wave sine ROM in Q2.14, round to Q16.8, add the offset and saturate; the
// saturated flag marks a clamped coordinate and the last-vertex mark rides along.
// Throughput is one vertex per clock while the world side does not stall. A vertex passes
// 11 register stages, set by the angle reduction, the reciprocal division that forms
// the table index, the registered ROM read, the rotation multipliers, rounding, offset
// add and clamp. A stall on the world side holds the pipeline up to the first empty
// stage; empty stages still fill behind it. Registers must be written only while no
// vertex is in flight; the block itself does not enforce this.
module vertex_scale_rotate_translate_top #(
	parameter int COORD_WIDTH = vsrt_pkg::COORD_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Register port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [vsrt_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [vsrt_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [vsrt_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready,
	// Local vertex words
	input  logic                                 local_valid,
	output logic                                 local_stall,
	input  logic signed [COORD_WIDTH-1:0]        local_x,
	input  logic signed [COORD_WIDTH-1:0]        local_y,
	input  logic                                 last_vertex,
	// World vertex words
	output logic                                 world_valid,
	input  logic                                 world_stall,
	output logic signed [COORD_WIDTH-1:0]        world_x,
	output logic signed [COORD_WIDTH-1:0]        world_y,
	output logic                                 world_last,
	output logic                                 saturated
);

	localparam int ND = vsrt_pkg::PIPE_DEPTH;

	vsrt_pkg::cfg_t       cfg;
	vsrt_pkg::trig_pair_t trig_s6;
	vsrt_pkg::pipe_en_t   adv;
	logic [ND-1:0]        valid_s;
	logic [ND-1:0]        last_s;

	vsrt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vsrt_trig u_trig (
		.clk     (clk),
		.adv     (adv),
		.angle   (cfg.angle),
		.trig_s6 (trig_s6)
	);

	vsrt_xform #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_xform (
		.clk         (clk),
		.adv         (adv),
		.local_x     (local_x),
		.local_y     (local_y),
		.cfg         (cfg),
		.trig_s6     (trig_s6),
		.world_x_s11 (world_x),
		.world_y_s11 (world_y),
		.sat_s11     (saturated)
	);

	// A stage advances when it is empty or the stage ahead advances
	always_comb begin
		adv[ND-1] = !valid_s[ND-1] || !world_stall;
		for (int k = ND - 2; k >= 0; k--) begin
			adv[k] = !valid_s[k] || adv[k+1];
		end
	end

	assign local_stall = !adv[0];
	assign world_valid = valid_s[ND-1];
	assign world_last  = last_s[ND-1];

	// Move valid bits along with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (adv[0]) begin
				valid_s[0] <= local_valid;
			end
			for (int k = 1; k < ND; k++) begin
				if (adv[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// Carry the last-vertex mark
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			last_s[0] <= last_vertex;
		end
		for (int k = 1; k < ND; k++) begin
			if (adv[k]) begin
				last_s[k] <= last_s[k-1];
			end
		end
	end

endmodule
